FILE: rtl/assert_macros.svh
// Assertion macros shared by the convolution filter RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever cond holds, prop holds too.
`define CV2D_ASSERT_SAME(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("cv2d same-cycle check failed");

// Next-cycle implication: whenever cond holds, prop holds in the next cycle.
`define CV2D_ASSERT_NEXT(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("cv2d next-cycle check failed");

`endif

FILE: rtl/cv2d_pkg.sv
// Types and fixed constants of the 5x5 convolution filter.
// Used by cv2d_front, cv2d_mac and the top level; depends on nothing.
package cv2d_pkg;

   localparam int PIX_W      = 8;
   localparam int COEFF_W    = 16;
   localparam int CIDX_W     = 5;
   localparam int FRAC_BITS  = 8;
   localparam int PIX_MAX    = 255;
   localparam int MAX_ROWS   = 4096;
   localparam int ROW_BITS   = $clog2(MAX_ROWS);
   localparam int H_BITS     = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_ADDR_W = 1;

   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic                      command;
      logic [CIDX_W-1:0]         coeff_index;
      logic signed [COEFF_W-1:0] coeff_value;
      logic [PIX_W-1:0]          pixel_in;
   } cv2d_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] filtered_pixel;
      logic             window_inside;
      logic             frame_last;
   } cv2d_rsp_type;

   // item passed from the raster front end to the arithmetic back end
   typedef struct packed {
      logic                      is_pixel;
      logic [CIDX_W-1:0]         coeff_index;
      logic signed [COEFF_W-1:0] coeff_value;
      logic                      in_frame;
      logic                      last;
   } cv2d_tag_type;

endpackage

FILE: rtl/cv2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cv2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cv2d_front.sv
// Raster front end: geometry registers, row/column counters, line store
// with its clearing sweep, and the first pipeline stage. Uses cv2d_pkg, cv2d_ram, assert_macros.svh.
`include "assert_macros.svh"
module cv2d_front import cv2d_pkg::*; #(
   parameter int KERNEL_SIZE = 5,
   parameter int MAX_LINE    = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [CSR_ADDR_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  cv2d_req_type                   req_data,
   output logic                           s1_valid,
   output cv2d_tag_type                   s1_tag,
   output logic [KERNEL_SIZE*PIX_W-1:0]   s1_column,
   input  logic                           s1_ready
);

   localparam int LINES    = KERNEL_SIZE - 1;
   localparam int LINE_W   = LINES * PIX_W;
   localparam int COL_BITS = $clog2(MAX_LINE);
   localparam int W_BITS   = $clog2(MAX_LINE + 1);
   localparam int CMP_W    = (W_BITS > CSR_DATA_W) ? W_BITS : CSR_DATA_W;
   localparam int W_RESET  = (FRAME_WIDTH_RESET > MAX_LINE) ? MAX_LINE : FRAME_WIDTH_RESET;

   logic [W_BITS-1:0]   w_ff, w_clamp;
   logic [H_BITS-1:0]   h_ff, h_clamp;
   logic [CMP_W-1:0]    wdata_ext;
   logic [COL_BITS-1:0] col_ff, col_in, col_cur;
   logic [ROW_BITS-1:0] row_ff, row_in, row_cur;
   logic [H_BITS-1:0]   row_t, row_inc;
   logic [W_BITS-1:0]   col_inc;
   logic                col_wrap, in_frame, last;
   logic                clearing_ff;
   logic [COL_BITS-1:0] clear_addr_ff;
   logic                s1_valid_ff;
   cv2d_tag_type        s1_tag_ff;
   logic [PIX_W-1:0]    s1_pixel_ff;
   logic [COL_BITS-1:0] s1_col_ff;
   logic                s1_en, req_fire, pix_fire, s1_fire;
   logic [LINE_W-1:0]   ram_rdata, ram_wdata;
   logic [COL_BITS-1:0] ram_waddr;
   logic                ram_wen;
   logic [KERNEL_SIZE*PIX_W-1:0] column;

   // geometry clamp on write
   always_comb begin
      wdata_ext = CMP_W'(csr_wdata);
      if (wdata_ext < CMP_W'(KERNEL_SIZE)) begin
         w_clamp = W_BITS'(KERNEL_SIZE);
      end else if (wdata_ext > CMP_W'(MAX_LINE)) begin
         w_clamp = W_BITS'(MAX_LINE);
      end else begin
         w_clamp = W_BITS'(wdata_ext);
      end
      if (csr_wdata < CSR_DATA_W'(KERNEL_SIZE)) begin
         h_clamp = H_BITS'(KERNEL_SIZE);
      end else if (csr_wdata > CSR_DATA_W'(MAX_ROWS)) begin
         h_clamp = H_BITS'(MAX_ROWS);
      end else begin
         h_clamp = H_BITS'(csr_wdata);
      end
   end

   // position of this pixel, after wrapping counters left beyond a changed geometry
   always_comb begin
      col_wrap = W_BITS'(col_ff) >= w_ff;
      col_cur  = col_wrap ? '0 : col_ff;
      row_t    = H_BITS'(row_ff) + H_BITS'(col_wrap);
      row_cur  = (row_t >= h_ff) ? '0 : ROW_BITS'(row_t);
      in_frame = (row_cur >= ROW_BITS'(KERNEL_SIZE - 1)) &&
                 (col_cur >= COL_BITS'(KERNEL_SIZE - 1));
      last     = (H_BITS'(row_cur) == h_ff - H_BITS'(1)) &&
                 (W_BITS'(col_cur) == w_ff - W_BITS'(1));
      col_inc  = W_BITS'(col_cur) + W_BITS'(1);
      row_inc  = H_BITS'(row_cur) + H_BITS'(1);
      if (col_inc >= w_ff) begin
         col_in = '0;
         row_in = (row_inc >= h_ff) ? '0 : ROW_BITS'(row_inc);
      end else begin
         col_in = COL_BITS'(col_inc);
         row_in = row_cur;
      end
   end

   assign s1_en     = ~s1_valid_ff | s1_ready;
   assign req_ready = s1_en & ~clearing_ff;
   assign req_fire  = req_valid & req_ready;
   assign pix_fire  = req_fire & (req_data.command == CMD_PIXEL);
   assign s1_fire   = s1_valid_ff & s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff          <= W_BITS'(W_RESET);
         h_ff          <= H_BITS'(FRAME_HEIGHT_RESET);
         col_ff        <= '0;
         row_ff        <= '0;
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  w_ff <= w_clamp;
               CSR_FRAME_HEIGHT: h_ff <= h_clamp;
               default: ;
            endcase
         end
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + COL_BITS'(1);
            if (clear_addr_ff == COL_BITS'(MAX_LINE - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (pix_fire) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (s1_en) begin
            s1_valid_ff <= req_fire;
         end
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_tag_ff.is_pixel    <= req_data.command == CMD_PIXEL;
         s1_tag_ff.coeff_index <= req_data.coeff_index;
         s1_tag_ff.coeff_value <= req_data.coeff_value;
         s1_tag_ff.in_frame    <= in_frame;
         s1_tag_ff.last        <= last;
         s1_pixel_ff           <= req_data.pixel_in;
         s1_col_ff             <= col_cur;
      end
   end

   // oldest line in the low byte, new pixel on top
   assign column = {s1_pixel_ff, ram_rdata};

   // write back the column shifted up one line; the sweep zeroes the store after reset
   always_comb begin
      if (clearing_ff) begin
         ram_wen   = 1'b1;
         ram_waddr = clear_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_wen   = s1_fire & s1_tag_ff.is_pixel;
         ram_waddr = s1_col_ff;
         ram_wdata = column[KERNEL_SIZE*PIX_W-1:PIX_W];
      end
   end

   cv2d_ram #(
      .WIDTH(LINE_W),
      .DEPTH(MAX_LINE)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (ram_wen),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (pix_fire),
      .rd_addr(col_cur),
      .rd_data(ram_rdata)
   );

   assign s1_valid  = s1_valid_ff;
   assign s1_tag    = s1_tag_ff;
   assign s1_column = column;

   `CV2D_ASSERT_SAME(a_clear_excludes_pipe, clearing_ff, !s1_valid_ff)
   `CV2D_ASSERT_NEXT(a_line_data_holds, s1_valid_ff && !s1_ready, $stable(ram_rdata))

endmodule

FILE: rtl/cv2d_mac.sv
// Arithmetic back end: coefficient registers, 5x5 window, products,
// row sums, final sum with clamp and the result register. Uses cv2d_pkg, assert_macros.svh.
`include "assert_macros.svh"
module cv2d_mac import cv2d_pkg::*; #(
   parameter int KERNEL_SIZE = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         s1_valid,
   output logic                         s1_ready,
   input  cv2d_tag_type                 s1_tag,
   input  logic [KERNEL_SIZE*PIX_W-1:0] s1_column,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output cv2d_rsp_type                 rsp_data
);

   localparam int KK      = KERNEL_SIZE * KERNEL_SIZE;
   localparam int KK_BITS = $clog2(KK);
   localparam int PROD_W  = PIX_W + 1 + COEFF_W;
   localparam int RSUM_W  = PROD_W + $clog2(KERNEL_SIZE);
   localparam int SUM_W   = RSUM_W + $clog2(KERNEL_SIZE);
   localparam int Q_W     = SUM_W - FRAC_BITS;

   logic signed [COEFF_W-1:0] coeff_ff [KK];
   logic [PIX_W-1:0]          win_ff   [KK];
   logic [PIX_W-1:0]          win_in   [KK];
   logic signed [PROD_W-1:0]  prod_ff  [KK];
   logic signed [PROD_W-1:0]  prod_in  [KK];
   logic signed [RSUM_W-1:0]  rsum_ff  [KERNEL_SIZE];
   logic signed [RSUM_W-1:0]  rsum_in  [KERNEL_SIZE];
   logic signed [SUM_W-1:0]   total;
   logic [Q_W-1:0]            quot;
   logic [PIX_W-1:0]          clamped;
   logic [KK_BITS-1:0]        coeff_sel;

   logic s2_valid_ff, s2_inside_ff, s2_last_ff;
   logic s3_valid_ff, s3_inside_ff, s3_last_ff;
   logic rsp_valid_ff;
   cv2d_rsp_type rsp_ff;
   logic out_en, s3_en, s2_en, s1_fire, pix_fire, load_ok;

   assign out_en   = ~rsp_valid_ff | rsp_ready;
   assign s3_en    = ~s3_valid_ff | out_en;
   assign s2_en    = ~s2_valid_ff | s3_en;
   assign s1_ready = s2_en;
   assign s1_fire  = s1_valid & s2_en;
   assign pix_fire = s1_fire & s1_tag.is_pixel;
   assign load_ok  = s1_fire & ~s1_tag.is_pixel & (32'(s1_tag.coeff_index) < KK);
   assign coeff_sel = KK_BITS'(s1_tag.coeff_index);

   // shift the window left and take the new column on the right;
   // the kernel is flipped, so window tap i meets coefficient KK-1-i
   always_comb begin
      for (int dy = 0; dy < KERNEL_SIZE; dy++) begin
         for (int dx = 0; dx < KERNEL_SIZE - 1; dx++) begin
            win_in[dy*KERNEL_SIZE + dx] = win_ff[dy*KERNEL_SIZE + dx + 1];
         end
         win_in[dy*KERNEL_SIZE + KERNEL_SIZE - 1] = s1_column[dy*PIX_W +: PIX_W];
      end
      for (int i = 0; i < KK; i++) begin
         prod_in[i] = $signed({1'b0, win_in[i]}) * coeff_ff[KK - 1 - i];
      end
   end

   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         rsum_in[r] = '0;
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            rsum_in[r] = rsum_in[r] + RSUM_W'(prod_ff[r*KERNEL_SIZE + c]);
         end
      end
   end

   // negative gives zero, otherwise drop the fraction and saturate
   always_comb begin
      total = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         total = total + SUM_W'(rsum_ff[r]);
      end
      quot = total[SUM_W-1:FRAC_BITS];
      if (total[SUM_W-1]) begin
         clamped = '0;
      end else if (quot > Q_W'(PIX_MAX)) begin
         clamped = PIX_W'(PIX_MAX);
      end else begin
         clamped = quot[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KK; i++) begin
            coeff_ff[i] <= '0;
            win_ff[i]   <= '0;
         end
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_ok) begin
            coeff_ff[coeff_sel] <= s1_tag.coeff_value;
         end
         if (pix_fire) begin
            win_ff <= win_in;
         end
         if (s2_en) begin
            s2_valid_ff <= pix_fire;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         prod_ff      <= prod_in;
         s2_inside_ff <= s1_tag.in_frame;
         s2_last_ff   <= s1_tag.last;
      end
      if (s3_en && s2_valid_ff) begin
         rsum_ff      <= rsum_in;
         s3_inside_ff <= s2_inside_ff;
         s3_last_ff   <= s2_last_ff;
      end
      if (out_en && s3_valid_ff) begin
         rsp_ff.filtered_pixel <= s3_inside_ff ? clamped : '0;
         rsp_ff.window_inside  <= s3_inside_ff;
         rsp_ff.frame_last     <= s3_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CV2D_ASSERT_SAME(a_last_is_inside, rsp_valid_ff && rsp_ff.frame_last, rsp_ff.window_inside)
   `CV2D_ASSERT_SAME(a_border_is_zero, rsp_valid_ff && !rsp_ff.window_inside, rsp_ff.filtered_pixel == '0)

endmodule

FILE: rtl/conv2d_5x5_clamped_filter_unit.sv
// Top level of the streaming 5x5 convolution filter with clamped output.
// Depends on cv2d_pkg, cv2d_front and cv2d_mac.
//
//   port group  direction  handshake          payload
//   req_        in         req_valid/ready    cv2d_req_type (load or pixel)
//   rsp_        out        rsp_valid/ready    cv2d_rsp_type (one per pixel)
//   csr_        in         csr_write          csr_index, csr_wdata
//
// One item (pixel or coefficient load) is taken per cycle while req_ready
// is high; a pixel's result is registered through the stages line read,
// products, row sums and final sum in turn. Loads give no result.
// After reset the line store is swept to zero, one column a cycle, over all
// MAX_LINE columns; req_ready stays low meanwhile, register writes still land.
// A stalled rsp_ side fills the internal stages before req_ready drops.
module conv2d_5x5_clamped_filter_unit import cv2d_pkg::*; #(
   parameter int KERNEL_SIZE = 5,
   parameter int MAX_LINE    = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cv2d_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cv2d_rsp_type          rsp_data
);

   logic                         s1_valid, s1_ready;
   cv2d_tag_type                 s1_tag;
   logic [KERNEL_SIZE*PIX_W-1:0] s1_column;

   cv2d_front #(
      .KERNEL_SIZE(KERNEL_SIZE),
      .MAX_LINE   (MAX_LINE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .s1_valid (s1_valid),
      .s1_tag   (s1_tag),
      .s1_column(s1_column),
      .s1_ready (s1_ready)
   );

   cv2d_mac #(
      .KERNEL_SIZE(KERNEL_SIZE)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_tag   (s1_tag),
      .s1_column(s1_column),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule
